FILE: rtl/b32enc_pkg.sv
// ----------------------------------------------------------------------------
// Base32 encoder package
// Shared types, constants and the character lookup for the Base32 encoder.
// ----------------------------------------------------------------------------
package b32enc_pkg;

  localparam int unsigned GroupChars = 8;
  localparam int unsigned BlockW     = 40;
  localparam int unsigned NcharsW    = 4;
  localparam int unsigned CountW     = 3;

  // Depth of the group queue between front and back; a power of two.
  localparam int unsigned GqDepth  = 2;
  localparam int unsigned GqPtrW   = $clog2(GqDepth);
  localparam int unsigned GqCountW = $clog2(GqDepth + 1);

  localparam logic [7:0] PadChar = 8'h3D;

  // One complete or final group, ready to be turned into characters.
  typedef struct packed {
    logic [BlockW-1:0]  block;   // first byte in the top bits
    logic [NcharsW-1:0] nchars;  // data characters, the rest is padding
    logic               fin;     // group ends the message
  } group_t;

  // Maps a five-bit value onto the upper-case alphabet A-Z, 2-7.
  function automatic logic [7:0] b32_char(input logic [4:0] v);
    logic [7:0] r;
    if (v < 5'd26) begin
      r = 8'h41 + {3'b000, v};
    end else begin
      r = 8'h32 + {3'b000, v - 5'd26};
    end
    return r;
  endfunction

  // Data characters for a partial group of n bytes: ceil(8n/5).
  function automatic logic [NcharsW-1:0] b32_nchars(input logic [CountW-1:0] n);
    logic [NcharsW-1:0] r;
    case (n)
      3'd1:    r = 4'd2;
      3'd2:    r = 4'd4;
      3'd3:    r = 4'd5;
      3'd4:    r = 4'd7;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/b32enc_front.sv
// ----------------------------------------------------------------------------
// Base32 encoder front end
// Collects input bytes into groups of up to five and hands finished groups on.
// ----------------------------------------------------------------------------
module b32enc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                grp_push_o,
  output b32enc_pkg::group_t  grp_o
);
  import b32enc_pkg::*;

  logic [31:0]       pend_q, pend_d;
  logic [CountW-1:0] count_q, count_d;
  logic [31:0]       merged;
  logic [CountW-1:0] count_inc;

  always_comb begin
    merged    = pend_q;
    count_inc = count_q + 3'd1;
    case (count_q)
      3'd0:    merged[31:24] = data_byte_i;
      3'd1:    merged[23:16] = data_byte_i;
      3'd2:    merged[15:8]  = data_byte_i;
      3'd3:    merged[7:0]   = data_byte_i;
      default: merged        = pend_q;
    endcase

    pend_d       = pend_q;
    count_d      = count_q;
    grp_push_o   = 1'b0;
    grp_o.block  = {merged, 8'h00};
    grp_o.nchars = b32_nchars(count_inc);
    grp_o.fin    = last_byte_i;

    if (accept_i) begin
      if (count_q == 3'd4) begin
        // Fifth byte completes the group.
        grp_push_o   = 1'b1;
        grp_o.block  = {pend_q, data_byte_i};
        grp_o.nchars = NcharsW'(GroupChars);
        pend_d       = '0;
        count_d      = '0;
      end else if (last_byte_i) begin
        grp_push_o = 1'b1;
        pend_d     = '0;
        count_d    = '0;
      end else begin
        pend_d  = merged;
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      count_q <= '0;
    end else begin
      pend_q  <= pend_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/b32enc_gq.sv
// ----------------------------------------------------------------------------
// Base32 encoder group queue
// A short queue of finished groups between front end and back end.
// ----------------------------------------------------------------------------
module b32enc_gq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b32enc_pkg::group_t  data_i,
  input  logic                pop_i,
  output b32enc_pkg::group_t  data_o,
  output logic                full_o,
  output logic                empty_o
);
  import b32enc_pkg::*;

  group_t              mem_q [GqDepth];
  logic [GqPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [GqCountW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == GqCountW'(GqDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + GqPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + GqPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + GqCountW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - GqCountW'(1);
      end
    end
  end

endmodule

FILE: rtl/b32enc_back.sv
// ----------------------------------------------------------------------------
// Base32 encoder back end
// Turns one group into eight characters, one a cycle while the output register is empty or popped.
// ----------------------------------------------------------------------------
module b32enc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b32enc_pkg::group_t  grp_i,
  input  logic                grp_empty_i,
  output logic                grp_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [7:0]          out_char_o,
  output logic                last_char_o
);
  import b32enc_pkg::*;

  logic               busy_q;
  logic [BlockW-1:0]  blk_q;
  logic [NcharsW-1:0] nchars_q;
  logic               fin_q;
  logic [2:0]         idx_q;
  logic               ovalid_q;
  logic [7:0]         ochar_q;
  logic               olast_q;
  logic               advance, load, last_idx;
  logic [7:0]         next_char;

  assign advance   = busy_q && (!ovalid_q || pop_i);
  assign last_idx  = (idx_q == 3'd7);
  assign load      = (!busy_q || (advance && last_idx)) && !grp_empty_i;
  assign grp_pop_o = load;
  assign next_char = ({1'b0, idx_q} < nchars_q) ? b32_char(blk_q[BlockW-1 -: 5]) : PadChar;

  assign empty_o     = !ovalid_q;
  assign out_char_o  = ochar_q;
  assign last_char_o = olast_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      blk_q    <= grp_i.block;
      nchars_q <= grp_i.nchars;
      fin_q    <= grp_i.fin;
    end else if (advance) begin
      blk_q <= {blk_q[BlockW-6:0], 5'b00000};
    end
    if (advance) begin
      ochar_q <= next_char;
      olast_q <= fin_q && last_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (advance) begin
        idx_q <= idx_q + 3'd1;
        if (last_idx) begin
          busy_q <= 1'b0;
        end
      end
      if (advance) begin
        ovalid_q <= 1'b1;
      end else if (pop_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/base32_encoder.sv
// ----------------------------------------------------------------------------
// Base32 encoder
// Encodes a byte stream as RFC 4648 Base32 text with padding, upper case.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-------------------------------
//  input    | push, full           | data_byte_i[7:0], last_byte_i
//  result   | empty, pop           | out_char_o[7:0], last_char_o
//
// A byte is taken in every cycle in which the group queue has room; a byte
// that completes or ends a group enters the queue at that same edge.
// The back end emits one character a cycle while its output register is empty or
// popped, eight per group; a group moves from the queue into the group register,
// then to the output register. Reset clears pending bytes, queue and output.
// While pop stays low only the back end stalls, until the queue fills and full rises.
// ----------------------------------------------------------------------------
module base32_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);
  import b32enc_pkg::*;

  logic   accept;
  logic   grp_push, grp_pop, gq_full, gq_empty;
  group_t grp_in, grp_out;

  // The queue being full is the only thing that holds the input side back;
  // every transaction that pushes a group needs a free slot.
  assign full   = gq_full;
  assign accept = push && !gq_full;

  // Front end: gathers bytes and classifies each as filling, completing a
  // full group or ending the message with a partial group.
  b32enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .grp_push_o  (grp_push),
    .grp_o       (grp_in)
  );

  // Group queue: decouples byte intake from character output.
  b32enc_gq u_gq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .data_i  (grp_in),
    .pop_i   (grp_pop),
    .data_o  (grp_out),
    .full_o  (gq_full),
    .empty_o (gq_empty)
  );

  // Back end: slices each group into five-bit codes, adds padding and
  // marks the final character of the message.
  b32enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp_out),
    .grp_empty_i (gq_empty),
    .grp_pop_o   (grp_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base32 encoder testbench
// Sends byte messages into the encoder and checks every character that comes
// out against a predictor of RFC 4648 Base32 with padding. A short directed
// set covers partial groups of one to four bytes, a full group that ends a
// message, a full group in mid-message and the extreme byte values. Random
// messages follow, with random idling on both sides. One stretch holds the
// result side off for a long time so that the encoder fills up.
// ----------------------------------------------------------------------------
module tb;

  import b32enc_pkg::*;

  // The watchdog gives up after this many cycles without a transaction.
  localparam int unsigned IdleLimit    = 2000;
  // Length of the long hold-off on the result side.
  localparam int unsigned HoldCycles   = 300;
  // Cycles allowed after the last character for stray output to show up.
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned TargetItems  = 330;
  localparam int unsigned BurstItems   = 60;

  // Directed bytes, written as {last flag, byte}.
  localparam int unsigned DirectedLen = 22;
  localparam logic [8:0] DirectedSeq [DirectedLen] = '{
    9'h100,                                    // one zero byte
    9'h1FF,                                    // one all-ones byte
    9'h066, 9'h16F,                            // two bytes
    9'h080, 9'h001, 9'h1FE,                    // three bytes
    9'h055, 9'h0AA, 9'h00F, 9'h1F0,            // four bytes
    9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,    // full group ends the message
    9'h000, 9'h000, 9'h000, 9'h000, 9'h000,    // full group in mid-message,
    9'h1A5                                     // then a one-byte tail
  };

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } enc_char_t;

  // Scoreboard: holds a copy of the encoder's pending bytes, turns each byte
  // transaction into the characters it should release, and compares every
  // character transaction with the oldest one still waiting.
  class b32_scoreboard;
    string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
    logic [31:0] held_bytes;
    int unsigned held_count;
    int unsigned errors;
    enc_char_t   due_chars[$];

    function new();
      held_bytes = '0;
      held_count = 0;
      errors     = 0;
    endfunction

    function int unsigned outstanding();
      return due_chars.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_byte(logic [7:0] data, logic fin);
      logic [39:0] block;
      int unsigned nchars;
      logic [4:0]  idx;
      enc_char_t   c;
      if (held_count == 4) begin
        block  = {held_bytes, data};
        nchars = GroupChars;
      end else begin
        held_bytes = held_bytes | ({data, 24'h0} >> (8 * held_count));
        held_count++;
        if (!fin) begin
          return;
        end
        block  = {held_bytes, 8'h00};
        nchars = (held_count * 8 + 4) / 5;
      end
      for (int i = 0; i < GroupChars; i++) begin
        idx   = 5'(block >> (35 - 5 * i));
        c.ch  = (i < nchars) ? 8'(alphabet.getc(idx)) : PadChar;
        c.fin = fin && (i == GroupChars - 1);
        due_chars.push_back(c);
      end
      held_bytes = '0;
      held_count = 0;
    endfunction

    task check_char(logic [7:0] ch, logic fin);
      enc_char_t want;
      if (due_chars.size() == 0) begin
        report($sformatf("character %h with nothing expected", ch));
      end else begin
        want = due_chars.pop_front();
        if (ch !== want.ch) begin
          report($sformatf("out_char_o %h, expected %h", ch, want.ch));
        end
        if (fin !== want.fin) begin
          report($sformatf("last_char_o %b, expected %b (char %h)", fin, want.fin, want.ch));
        end
      end
    endtask
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       pop         = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_char_o;
  logic       last_char_o;

  b32_scoreboard sb = new();

  int unsigned items_sent    = 0;
  bit          hold_pop_req  = 1'b0;
  int unsigned idle_cycles   = 0;

  base32_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .empty       (empty),
    .pop         (pop),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Inputs change only just after a rising edge, and the outputs only at one,
  // so the handshake signals are stable at the falling edge. Both sides look
  // there to decide whether the coming edge completes a transaction.

  // Offers one byte, after an optional gap, and returns at the rising edge
  // that takes it in. The predictor is told of the byte at that same edge.
  task automatic send_byte(logic [7:0] data, logic fin, bit no_idle);
    int unsigned gap;
    bit          taken;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= data;
    last_byte_i <= fin;
    do begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end while (!taken);
    sb.note_byte(data, fin);
    items_sent++;
  endtask

  // A message of random bytes; the final one carries the last flag.
  task automatic send_message(int unsigned len, bit no_idle);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1, no_idle);
    end
  endtask

  // Mostly short messages, so that every tail length turns up often; now and
  // then a long one that runs through many full groups.
  function automatic int unsigned draw_length();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 12);
  endfunction

  // Waits, on edges, until the encoder has handed over every character owed.
  task automatic wait_for_drain();
    while (sb.outstanding() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Result side: takes one character per transaction, idling at random
  // between them, and once takes a long break when the sender asks for it.
  initial begin : result_side
    int unsigned stall;
    int unsigned taken_count;
    bit          no_idle;
    bit          got;
    logic [7:0]  ch;
    logic        fin;
    taken_count = 0;
    no_idle     = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken_count % 16 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (hold_pop_req) begin
        hold_pop_req = 1'b0;
        stall += HoldCycles;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk_i);
        got = !empty;
        ch  = out_char_o;
        fin = last_char_o;
        @(posedge clk_i);
      end while (!got);
      sb.check_char(ch, fin);
      taken_count++;
    end
  end

  // Watchdog: a run that stops making transactions is a failure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("[%0t] no transaction for %0d cycles", $time, IdleLimit);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : byte_side
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed messages: every tail length, both kinds of full group and the
    // extreme byte values.
    for (int unsigned i = 0; i < DirectedLen; i++) begin
      send_byte(DirectedSeq[i][7:0], DirectedSeq[i][8], 1'b0);
    end

    // The sender stands still until every character owed has come out.
    push <= 1'b0;
    wait_for_drain();

    // Random messages, about a third of the items.
    while (items_sent < 130) begin
      send_message(draw_length(), $urandom_range(0, 3) == 0);
    end

    // The result side now stops for a long stretch while bytes keep coming
    // without gaps, so that the encoder fills up and raises full.
    hold_pop_req = 1'b1;
    send_message(BurstItems, 1'b1);

    while (items_sent < TargetItems) begin
      send_message(draw_length(), $urandom_range(0, 3) == 0);
    end
    push <= 1'b0;

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/b32enc_pkg.sv
rtl/b32enc_front.sv
rtl/b32enc_gq.sv
rtl/b32enc_back.sv
rtl/base32_encoder.sv
verif/tb.sv
